[rtl/assert_macros.svh]
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/idt_pkg.sv]
package idt_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_CHARS_DEF   = 20;
    localparam int IN_DATA_W       = 64;
    localparam int CHAR_W          = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_LEAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic lead;
        logic adv;
    } t_cmd;

    typedef struct packed {
        logic conv_last;
        logic char_last;
    } t_status;

endpackage

[rtl/idt_ctrl.sv]
module idt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  idt_pkg::t_status  i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output idt_pkg::t_cmd     o_cmd
);

    idt_pkg::t_state r_state;
    idt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            idt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = idt_pkg::S_CONV;
                end
            end
            idt_pkg::S_CONV: begin
                if (i_status.conv_last) begin
                    n_state = idt_pkg::S_LEAD;
                end
            end
            idt_pkg::S_LEAD: begin
                n_state = idt_pkg::S_EMIT;
            end
            idt_pkg::S_EMIT: begin
                if (i_out_ready && i_status.char_last) begin
                    n_state = idt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = idt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            idt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            idt_pkg::S_CONV: begin
                o_cmd.step = 1'b1;
            end
            idt_pkg::S_LEAD: begin
                o_cmd.lead = 1'b1;
            end
            idt_pkg::S_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.adv   = i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[rtl/idt_datapath.sv]
module idt_datapath #(
    parameter int VALUE_WIDTH = idt_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_CHARS   = idt_pkg::MAX_CHARS_DEF
) (
    input  logic                           i_clk,
    input  idt_pkg::t_cmd                  i_cmd,
    input  logic [idt_pkg::IN_DATA_W-1:0]  i_value,
    output idt_pkg::t_status               o_status,
    output logic [idt_pkg::CHAR_W-1:0]     o_char
);

    // Enough decimal digits for a magnitude of up to 2^(VALUE_WIDTH-1).
    localparam int NDIG  = (VALUE_WIDTH * 31) / 100 + 1;
    localparam int IDX_W = $clog2(NDIG);
    localparam int BIT_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(NDIG + MAX_CHARS + 2);

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [NDIG*4-1:0]      r_bcd;
    logic [BIT_W-1:0]       r_bitcnt;
    logic                   r_neg;
    logic                   r_sign_pend;
    logic [IDX_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_left;

    logic [VALUE_WIDTH-1:0] raw;
    logic [NDIG*4-1:0]      adj;
    logic [IDX_W-1:0]       msd;
    logic [CNT_W-1:0]       len;
    logic [3:0]             cur_digit;

    assign raw = i_value[VALUE_WIDTH-1:0];

    // Shift-and-add-3: every digit of five or more is corrected before the shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    // Position of the most significant non-zero digit; zero keeps one digit.
    always_comb begin
        msd = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                msd = IDX_W'(i);
            end
        end
    end

    assign len = CNT_W'(r_neg) + CNT_W'(msd) + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg    <= raw[VALUE_WIDTH-1];
            r_mag    <= raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
            r_bcd    <= '0;
            r_bitcnt <= '0;
        end
        if (i_cmd.step) begin
            r_bcd    <= {adj[NDIG*4-2:0], r_mag[VALUE_WIDTH-1]};
            r_mag    <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
            r_bitcnt <= r_bitcnt + BIT_W'(1);
        end
        if (i_cmd.lead) begin
            r_sign_pend <= r_neg;
            r_idx       <= msd;
            r_left      <= (len > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : len;
        end
        if (i_cmd.adv) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else begin
                r_idx <= r_idx - IDX_W'(1);
            end
            r_left <= r_left - CNT_W'(1);
        end
    end

    assign cur_digit = r_bcd[r_idx*4 +: 4];
    assign o_char    = r_sign_pend ? idt_pkg::CHAR_MINUS
                                   : (idt_pkg::CHAR_ZERO + {4'd0, cur_digit});

    assign o_status.conv_last = (r_bitcnt == BIT_W'(VALUE_WIDTH - 1));
    assign o_status.char_last = (r_left == CNT_W'(1));

endmodule

[rtl/integer_to_decimal_text_core.sv]
// Converts one signed integer per input beat into its decimal ASCII text, sent
// one character per output beat, most significant digit first, with a leading
// '-' for negative values and tlast on the final character. The low VALUE_WIDTH
// bits of the input are taken as a two's-complement number, and the text is cut
// after MAX_CHARS characters. An item is loaded, converted to BCD by bit-serial
// shift-and-add-3 conversion, its leading digit is found, and then its text is
// sent one character per cycle while the output is not stalled. The next value
// is accepted once the last character has been taken.
module integer_to_decimal_text_core #(
    parameter int VALUE_WIDTH = idt_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_CHARS   = idt_pkg::MAX_CHARS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [idt_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [63:0] value
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [idt_pkg::CHAR_W-1:0]     o_m_tdata,   // [7:0] char_code
    output logic                           o_m_tlast
);

    idt_pkg::t_cmd    cmd;
    idt_pkg::t_status status;

    idt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (status),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (cmd)
    );

    idt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_CHARS   (MAX_CHARS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_value  (i_s_tdata),
        .o_status (status),
        .o_char   (o_m_tdata)
    );

    assign o_m_tlast = status.char_last;

endmodule

[rtl/idt_checker.sv]
`include "assert_macros.svh"

module idt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [idt_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [idt_pkg::CHAR_W-1:0]     o_m_tdata,
    input logic                           o_m_tlast
);

    // One value at a time: no new beat is taken while characters are still going out.
    `ASSERT_NEVER(a_no_overlap, i_clk, i_rst_n, o_s_tready && o_m_tvalid, "input ready while output valid")

    `ASSERT_PROP(a_busy_after_accept, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "ready stayed high after an input beat")

    `ASSERT_PROP(a_char_set, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata == idt_pkg::CHAR_MINUS || (o_m_tdata >= idt_pkg::CHAR_ZERO && o_m_tdata <= idt_pkg::CHAR_ZERO + 8'd9)), "character is neither minus nor digit")

    `ASSERT_PROP(a_stall_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)), "output beat changed while stalled")

    `ASSERT_PROP(a_ready_after_last, i_clk, i_rst_n, (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready, "not ready after the final character")

endmodule

bind integer_to_decimal_text_core idt_checker u_idt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

[tb/integer_to_decimal_text_core_test.sv]
module integer_to_decimal_text_core_test;

    localparam int VW         = idt_pkg::VALUE_WIDTH_DEF;
    localparam int TEXT_LIMIT = idt_pkg::MAX_CHARS_DEF;
    localparam int RANDOM_VALUES = 110;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN_WAIT = 120;

    typedef struct {
        logic [idt_pkg::CHAR_W-1:0] code;
        logic                       last;
    } t_text_char;

    // Holds the characters still owed by the block and checks each output beat against them.
    class decimal_text_board;
        t_text_char expected_text[$];
        int         error_count;
        int         values_noted;
        int         negatives_noted;
        int         chars_checked;

        function new();
            error_count     = 0;
            values_noted    = 0;
            negatives_noted = 0;
            chars_checked   = 0;
        endfunction

        task report(input string what);
            error_count++;
            $display("MISMATCH: %s", what);
        endtask

        function int pending();
            return expected_text.size();
        endfunction

        // Works out the decimal text of one accepted value.
        task note_value(input logic [idt_pkg::IN_DATA_W-1:0] value);
            logic [63:0]                mask;
            logic [63:0]                raw;
            logic [63:0]                mag;
            logic                       neg;
            logic [idt_pkg::CHAR_W-1:0] text[$];
            t_text_char                 entry;
            mask = {64{1'b1}} >> (64 - VW);
            raw  = 64'(value) & mask;
            neg  = raw[VW-1];
            // The magnitude is taken unsigned, so the most negative value keeps its true size.
            mag  = neg ? ((~raw + 64'd1) & mask) : raw;
            do begin
                text.push_front(idt_pkg::CHAR_ZERO + idt_pkg::CHAR_W'(mag % 64'd10));
                mag = mag / 64'd10;
            end while (mag != 64'd0);
            if (neg)
                text.push_front(idt_pkg::CHAR_MINUS);
            while (text.size() > TEXT_LIMIT)
                void'(text.pop_back());
            foreach (text[i]) begin
                entry.code = text[i];
                entry.last = (i == text.size() - 1);
                expected_text.push_back(entry);
            end
            values_noted++;
            if (neg)
                negatives_noted++;
        endtask

        task check_char(input logic [idt_pkg::CHAR_W-1:0] code, input logic last);
            t_text_char want;
            if (expected_text.size() == 0) begin
                report($sformatf("character 0x%02h last=%0b with no text pending", code, last));
                return;
            end
            want = expected_text.pop_front();
            chars_checked++;
            if (code !== want.code)
                report($sformatf("char_code 0x%02h, expected 0x%02h", code, want.code));
            if (last !== want.last)
                report($sformatf("last %0b on char 0x%02h, expected %0b", last, code, want.last));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [idt_pkg::IN_DATA_W-1:0] i_s_tdata = '0;    // [63:0] value
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [idt_pkg::CHAR_W-1:0]    o_m_tdata;         // [7:0] char_code
    logic                          o_m_tlast;

    decimal_text_board board = new();

    integer_to_decimal_text_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            board.note_value(i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_char(o_m_tdata, o_m_tlast);
    end

    function automatic logic [63:0] negate(input logic [63:0] v);
        return ~v + 64'd1;
    endfunction

    function automatic logic [63:0] power_of_ten(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++)
            p = p * 64'd10;
        return p;
    endfunction

    // Mixes full-width noise with values aimed at digit-count boundaries and the extremes.
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 999));
            2: v = power_of_ten($urandom_range(0, 18)) - 64'($urandom_range(0, 2)) + 64'd1;
            3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            4: v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20));
            default: v = 64'd1 << $urandom_range(0, 63);
        endcase
        if ($urandom_range(0, 1))
            v = negate(v);
        return v;
    endfunction

    task automatic send_value(input logic [idt_pkg::IN_DATA_W-1:0] value);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // The receiver changes its stall pattern every so often; once it holds off for a long
    // stretch so that the block backs up and refuses input.
    initial begin : receiver
        int mode;
        int span;
        int stretch;
        stretch = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            stretch++;
            if (stretch == 6) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 80);
            for (int c = 0; c < span; c++) begin
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= 1'($urandom_range(0, 1));
                    2: i_m_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_tready <= ((c % 5) < 3);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : limit
        #800000;
        $display("Timeout with %0d characters still pending", board.pending());
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] values[$];
        int          burst_left;
        int          gap;
        values = '{
            64'd0, 64'd1, negate(64'd1), 64'd9, 64'd10, negate(64'd9), negate(64'd10),
            64'd99, 64'd100, 64'd12345, negate(64'd12345),
            power_of_ten(18), power_of_ten(18) - 64'd1, negate(power_of_ten(18)),
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd1234567890123456789
        };
        for (int n = 0; n < RANDOM_VALUES; n++)
            values.push_back(pick_value());

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = 0;
        foreach (values[i]) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            send_value(values[i]);
            burst_left--;
        end
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);

        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Converted %0d values (%0d negative), %0d characters checked.",
                 board.values_noted, board.negatives_noted, board.chars_checked);
        $display("Covered zero, both extremes, digit-count boundaries and output back-pressure.");
        if (board.error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", board.error_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
